### sv/iq_delay_and_imbalance_correct_assert.svh
// Assertion macros for the checker file of the IQ correction block.
// Expects signals named clk and rst in the scope of use.
`ifndef IQ_DELAY_AND_IMBALANCE_CORRECT_ASSERT_SVH
`define IQ_DELAY_AND_IMBALANCE_CORRECT_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define IQC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IQC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/iqc_pkg.sv
// Package for the IQ delay and imbalance correction block.
// Holds widths, register codes, shared types and fixed-point helpers; no dependencies.
package iqc_pkg;

  localparam int SAMPLE_WIDTH   = 32;
  localparam int COEF_WIDTH     = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int PROD_WIDTH     = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int TRUNC_WIDTH    = PROD_WIDTH - COEF_FRAC_BITS;
  localparam int SUM_WIDTH      = TRUNC_WIDTH + 1;

  // Register file layout
  localparam int NUM_REGS    = 5;
  localparam int PADDR_WIDTH = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W   = PADDR_WIDTH - 2;
  localparam int PDATA_WIDTH = 32;

  localparam logic [REG_IDX_W-1:0] REG_DELAY_SELECT   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CORRECT_ENABLE = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_GAIN_A         = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_CROSS_C        = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_SCALE_D        = REG_IDX_W'(4);

  // Delay selector codes; the unused code means no delay
  localparam logic [1:0] DELAY_NONE = 2'd0;
  localparam logic [1:0] DELAY_I    = 2'd1;
  localparam logic [1:0] DELAY_Q    = 2'd2;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
    COEF_WIDTH'(64'd1 << COEF_FRAC_BITS);

  // Queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [PROD_WIDTH-1:0] TRUNC_BIAS =
    PROD_WIDTH'((64'd1 << COEF_FRAC_BITS) - 64'd1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX =
    {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN =
    {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] i;
    logic signed [SAMPLE_WIDTH-1:0] q;
  } iqc_pair_t;

  typedef struct packed {
    logic [1:0]                   delay_select;
    logic                         correct_enable;
    logic signed [COEF_WIDTH-1:0] gain_a;
    logic signed [COEF_WIDTH-1:0] cross_c;
    logic signed [COEF_WIDTH-1:0] scale_d;
  } iqc_cfg_t;

  // Drop the fraction bits of a product, rounding toward zero
  function automatic logic signed [TRUNC_WIDTH-1:0] trunc_frac(
    input logic signed [PROD_WIDTH-1:0] p
  );
    logic [PROD_WIDTH-1:0] adj;
    adj = p + (p[PROD_WIDTH-1] ? TRUNC_BIAS : '0);
    return adj[PROD_WIDTH-1:COEF_FRAC_BITS];
  endfunction

  // Clamp a wide signed value to the sample range
  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [SUM_WIDTH-1:0] v
  );
    logic [SUM_WIDTH-SAMPLE_WIDTH:0] top;
    top = v[SUM_WIDTH-1:SAMPLE_WIDTH-1];
    if (top == '0 || top == '1) begin
      return v[SAMPLE_WIDTH-1:0];
    end else if (v[SUM_WIDTH-1]) begin
      return SAMPLE_MIN;
    end else begin
      return SAMPLE_MAX;
    end
  endfunction

endpackage

### sv/iq_delay_and_imbalance_correct.sv
// IQ delay and imbalance correction, top level.
// Input channel in_valid/in_stall with sample_i, sample_q; output channel
// out_valid/out_stall with out_i, out_q. A beat moves when valid is high and
// stall is low. Coefficients and modes are set through the APB port
// (delay_select, correct_enable, gain_a, cross_c, scale_d at 0x0..0x10), to be
// written by the user only while no samples are in flight; the block does not
// enforce this. Throughput: one sample per cycle while the receiver does not
// stall, set by the fully pipelined back end (one multiply in stage one, two
// in parallel in stage three). An accepted sample passes through the two-entry
// queue and the three pipeline stages before the output register.
// When the receiver stalls, the output holds and the pipeline fills; the
// queue then fills and in_stall rises until the output drains.
// Reset clears the pipeline, empties the queue, zeroes the held sample and
// returns the registers to no delay, correction off, A = D = 1.0, C = 0.
// Depends on iqc_pkg, iqc_front, iqc_fifo and iqc_back.
module iq_delay_and_imbalance_correct (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [iqc_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [iqc_pkg::SAMPLE_WIDTH-1:0] sample_q,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [iqc_pkg::SAMPLE_WIDTH-1:0] out_i,
  output logic signed [iqc_pkg::SAMPLE_WIDTH-1:0] out_q,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [iqc_pkg::PADDR_WIDTH-1:0]         paddr,
  input  logic [iqc_pkg::PDATA_WIDTH-1:0]         pwdata,
  output logic [iqc_pkg::PDATA_WIDTH-1:0]         prdata,
  output logic                                    pready
);
  import iqc_pkg::*;

  iqc_cfg_t             cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_write;
  logic                 push, fifo_full, fifo_valid, pop;
  iqc_pair_t            push_data, pop_data;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_WIDTH-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_select   <= DELAY_NONE;
      cfg.correct_enable <= 1'b0;
      cfg.gain_a         <= COEF_ONE;
      cfg.cross_c        <= '0;
      cfg.scale_d        <= COEF_ONE;
    end else if (reg_write) begin
      case (reg_idx)
        REG_DELAY_SELECT:   cfg.delay_select   <= pwdata[1:0];
        REG_CORRECT_ENABLE: cfg.correct_enable <= pwdata[0];
        REG_GAIN_A:         cfg.gain_a         <= pwdata[COEF_WIDTH-1:0];
        REG_CROSS_C:        cfg.cross_c        <= pwdata[COEF_WIDTH-1:0];
        REG_SCALE_D:        cfg.scale_d        <= pwdata[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Register reads, coefficients sign extended
  always_comb begin
    case (reg_idx)
      REG_DELAY_SELECT:   prdata = PDATA_WIDTH'(cfg.delay_select);
      REG_CORRECT_ENABLE: prdata = PDATA_WIDTH'(cfg.correct_enable);
      REG_GAIN_A:         prdata = PDATA_WIDTH'(cfg.gain_a);
      REG_CROSS_C:        prdata = PDATA_WIDTH'(cfg.cross_c);
      REG_SCALE_D:        prdata = PDATA_WIDTH'(cfg.scale_d);
      default:            prdata = '0;
    endcase
  end

  iqc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_i  (sample_i),
    .sample_q  (sample_q),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  iqc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .valid     (fifo_valid),
    .pop_data  (pop_data)
  );

  iqc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fifo_valid (fifo_valid),
    .fifo_data  (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_i      (out_i),
    .out_q      (out_q)
  );

endmodule

### sv/iqc_front.sv
// Front end of the IQ correction block: input handshake and one-sample channel delay.
// Depends on iqc_pkg; feeds iqc_fifo.
module iqc_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  iqc_pkg::iqc_cfg_t                      cfg,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [iqc_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [iqc_pkg::SAMPLE_WIDTH-1:0] sample_q,
  input  logic                                   fifo_full,
  output logic                                   push,
  output iqc_pkg::iqc_pair_t                     push_data
);
  import iqc_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] held_sample;
  logic signed [SAMPLE_WIDTH-1:0] held_sample_next;

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  // Swap the selected channel with the held sample
  always_comb begin
    push_data.i      = sample_i;
    push_data.q      = sample_q;
    held_sample_next = held_sample;
    case (cfg.delay_select)
      DELAY_I: begin
        push_data.i      = held_sample;
        held_sample_next = sample_i;
      end
      DELAY_Q: begin
        push_data.q      = held_sample;
        held_sample_next = sample_q;
      end
      default: begin
        held_sample_next = held_sample;
      end
    endcase
  end

  // Advance the held sample on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      held_sample <= '0;
    end else if (push) begin
      held_sample <= held_sample_next;
    end
  end

endmodule

### sv/iqc_fifo.sv
// Small register queue between the front and back of the IQ correction block.
// Depends on iqc_pkg for the depth and the sample pair type.
module iqc_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  iqc_pkg::iqc_pair_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output iqc_pkg::iqc_pair_t pop_data
);
  import iqc_pkg::*;

  iqc_pair_t            entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;

  assign full     = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

### sv/iqc_back.sv
// Back end of the IQ correction block: four-stage gain, cross-term and saturation pipeline.
// Depends on iqc_pkg; drains iqc_fifo and drives the output channel.
module iqc_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  iqc_pkg::iqc_cfg_t                       cfg,
  input  logic                                    fifo_valid,
  input  iqc_pkg::iqc_pair_t                      fifo_data,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [iqc_pkg::SAMPLE_WIDTH-1:0] out_i,
  output logic signed [iqc_pkg::SAMPLE_WIDTH-1:0] out_q
);
  import iqc_pkg::*;

  logic                           s1_valid, s2_valid, s3_valid;
  logic                           adv1, adv2, adv3, adv4;
  logic signed [SAMPLE_WIDTH-1:0] s1_i, s1_q, s2_i, s2_q, s3_i, s3_q;
  logic signed [PROD_WIDTH-1:0]   s1_pa, s3_pc, s3_pd;
  logic signed [SAMPLE_WIDTH-1:0] gain_i;
  logic signed [SUM_WIDTH-1:0]    sum_q;
  logic signed [SAMPLE_WIDTH-1:0] corr_q;

  // A stage moves when it is empty or the one after it moves
  assign adv4 = !out_valid || !out_stall;
  assign adv3 = !s3_valid || adv4;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign pop  = fifo_valid && adv1;

  assign gain_i = sat_sample(SUM_WIDTH'(trunc_frac(s1_pa)));
  assign sum_q  = SUM_WIDTH'(trunc_frac(s3_pc)) + SUM_WIDTH'(trunc_frac(s3_pd));
  assign corr_q = sat_sample(sum_q);

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid  <= fifo_valid;
      if (adv2) s2_valid  <= s1_valid;
      if (adv3) s3_valid  <= s2_valid;
      if (adv4) out_valid <= s3_valid;
    end
  end

  // Stage 1: multiply I by the gain
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_i  <= fifo_data.i;
      s1_q  <= fifo_data.q;
      s1_pa <= fifo_data.i * cfg.gain_a;
    end
  end

  // Stage 2: round and clamp the scaled I, or pass it
  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_i <= cfg.correct_enable ? gain_i : s1_i;
      s2_q <= s1_q;
    end
  end

  // Stage 3: cross term from the scaled I and the Q scale
  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      s3_i  <= s2_i;
      s3_q  <= s2_q;
      s3_pc <= s2_i * cfg.cross_c;
      s3_pd <= s2_q * cfg.scale_d;
    end
  end

  // Stage 4: sum, clamp and hold the result for the receiver
  always_ff @(posedge clk) begin
    if (adv4 && s3_valid) begin
      out_i <= s3_i;
      out_q <= cfg.correct_enable ? corr_q : s3_q;
    end
  end

endmodule

### sv/iqc_checker.sv
// Port-level checks for the IQ correction block, bound to the top level.
// Depends on iqc_pkg and iq_delay_and_imbalance_correct_assert.svh.
`include "iq_delay_and_imbalance_correct_assert.svh"

module iqc_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic signed [iqc_pkg::SAMPLE_WIDTH-1:0] out_i,
  input logic signed [iqc_pkg::SAMPLE_WIDTH-1:0] out_q
);
  import iqc_pkg::*;

  // Hold a stalled result and its payload
  `IQC_ASSERT(a_out_valid_held, out_valid && out_stall |=> out_valid, "out_valid dropped while stalled")
  `IQC_ASSERT(a_out_payload_held, out_valid && out_stall |=> $stable(out_i) && $stable(out_q), "stalled output payload changed")

  // Input back-pressure only while the output holds a result, as the whole path is then full
  `IQC_ASSERT_ALWAYS(a_stall_needs_output, in_stall |-> out_valid || $past(rst), "in_stall high with output empty")

  // A beat accepted into a free-running path must reach the output
  `IQC_ASSERT(a_latency, in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "accepted beat did not arrive in time")

endmodule

bind iq_delay_and_imbalance_correct iqc_checker u_iqc_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for iq_delay_and_imbalance_correct: directed and random I/Q beats.
// Predicts every output beat on its own and compares it field by field; needs only iqc_pkg
// and the RTL.
module tb;
  import iqc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_WIDTH-1:0] sample_i = '0;
  logic signed [SAMPLE_WIDTH-1:0] sample_q = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] out_i;
  logic signed [SAMPLE_WIDTH-1:0] out_q;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr = '0;
  logic [PDATA_WIDTH-1:0] pwdata = '0;
  logic [PDATA_WIDTH-1:0] prdata;
  logic pready;

  iqc_pair_t raw_q[$];        // beats waiting to be driven
  iqc_pair_t corrected_q[$];  // predicted output beats, oldest first
  iqc_cfg_t  cfg_model;
  logic signed [SAMPLE_WIDTH-1:0] held_smp;
  int mismatches = 0;
  int send_idle_pct = 37;
  int recv_idle_pct = 71;
  int quiet_cycles = 0;

  iq_delay_and_imbalance_correct DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_fault(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Multiply by a coefficient and drop the fraction bits, rounding toward zero
  function automatic longint frac_mul(input longint x, input longint c);
    longint p;
    p = x * c;
    if (p < 0) return -((-p) >>> COEF_FRAC_BITS);
    return p >>> COEF_FRAC_BITS;
  endfunction

  function automatic longint clamp_sample(input longint v);
    longint hi;
    hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Apply the channel delay and the correction; advances the held sample
  function automatic iqc_pair_t iq_correct(input logic signed [SAMPLE_WIDTH-1:0] si_in,
                                           input logic signed [SAMPLE_WIDTH-1:0] sq_in);
    longint si, sq, t;
    iqc_pair_t r;
    si = si_in;
    sq = sq_in;
    case (cfg_model.delay_select)
      DELAY_I: begin
        t = held_smp;
        held_smp = si_in;
        si = t;
      end
      DELAY_Q: begin
        t = held_smp;
        held_smp = sq_in;
        sq = t;
      end
      default: ;
    endcase
    if (cfg_model.correct_enable) begin
      si = clamp_sample(frac_mul(si, $signed(cfg_model.gain_a)));
      sq = clamp_sample(frac_mul(si, $signed(cfg_model.cross_c)) +
                        frac_mul(sq, $signed(cfg_model.scale_d)));
    end
    r.i = si[SAMPLE_WIDTH-1:0];
    r.q = sq[SAMPLE_WIDTH-1:0];
    return r;
  endfunction

  // Input driver: hold a beat until taken, then load the next one or idle
  always @(posedge clk) begin : drive_in
    logic next_v;
    iqc_pair_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      held_smp = '0;
    end else begin
      next_v = in_valid;
      if (in_valid && !in_stall) begin
        corrected_q.push_back(iq_correct(sample_i, sample_q));
        next_v = 1'b0;
      end
      if (!next_v && raw_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = raw_q.pop_front();
        sample_i <= nxt.i;
        sample_q <= nxt.q;
        next_v = 1'b1;
      end
      in_valid <= next_v;
    end
  end

  // Output monitor: compare each beat with the oldest prediction, stall at random
  always @(posedge clk) begin : watch_out
    iqc_pair_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (corrected_q.size() == 0) begin
          report_fault($sformatf("unexpected beat i=%0d q=%0d", out_i, out_q));
        end else begin
          want = corrected_q.pop_front();
          if (out_i !== want.i)
            report_fault($sformatf("out_i expected %0d got %0d", want.i, out_i));
          if (out_q !== want.q)
            report_fault($sformatf("out_q expected %0d got %0d", want.q, out_q));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [PDATA_WIDTH-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DELAY_SELECT:   cfg_model.delay_select = val[1:0];
      REG_CORRECT_ENABLE: cfg_model.correct_enable = val[0];
      REG_GAIN_A:         cfg_model.gain_a = val[COEF_WIDTH-1:0];
      REG_CROSS_C:        cfg_model.cross_c = val[COEF_WIDTH-1:0];
      REG_SCALE_D:        cfg_model.scale_d = val[COEF_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input logic [1:0] dsel, input logic en,
                          input logic signed [COEF_WIDTH-1:0] a,
                          input logic signed [COEF_WIDTH-1:0] c,
                          input logic signed [COEF_WIDTH-1:0] d);
    write_reg(REG_DELAY_SELECT, PDATA_WIDTH'(dsel));
    write_reg(REG_CORRECT_ENABLE, PDATA_WIDTH'(en));
    write_reg(REG_GAIN_A, PDATA_WIDTH'(a));
    write_reg(REG_CROSS_C, PDATA_WIDTH'(c));
    write_reg(REG_SCALE_D, PDATA_WIDTH'(d));
    @(negedge clk);
  endtask

  task automatic push_pair(input logic signed [SAMPLE_WIDTH-1:0] i,
                           input logic signed [SAMPLE_WIDTH-1:0] q);
    iqc_pair_t p;
    p.i = i;
    p.q = q;
    raw_q.push_back(p);
  endtask

  // Wait until every beat is driven and every prediction has been compared
  task automatic drain();
    @(negedge clk);
    while (raw_q.size() != 0 || in_valid || corrected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_WIDTH'($urandom_range(4095)) - SAMPLE_WIDTH'(2048);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_WIDTH-1:0] pick_coef();
    case ($urandom_range(6))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return '0;
      3: return COEF_ONE;
      4: return COEF_ONE + COEF_WIDTH'($urandom_range(40000)) - COEF_WIDTH'(20000);
      default: return COEF_WIDTH'($urandom);
    endcase
  endfunction

  initial begin : stim
    int ph;
    int k;
    cfg_model.delay_select = DELAY_NONE;
    cfg_model.correct_enable = 1'b0;
    cfg_model.gain_a = COEF_ONE;
    cfg_model.cross_c = '0;
    cfg_model.scale_d = COEF_ONE;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: plain pass-through of the field extremes
    push_pair('0, '0);
    push_pair(SAMPLE_MAX, SAMPLE_MIN);
    push_pair(SAMPLE_MIN, SAMPLE_MAX);
    push_pair(-1, 1);
    drain();

    // Delay I, no correction: first beat shows the cleared held sample
    set_mode(DELAY_I, 1'b0, COEF_ONE, '0, COEF_ONE);
    push_pair(5, 6);
    push_pair(SAMPLE_MIN, SAMPLE_MAX);
    push_pair(SAMPLE_MAX, -1);
    drain();

    // Switch to delay Q with the held I value kept; largest coefficients saturate
    set_mode(DELAY_Q, 1'b1, COEF_MAX, COEF_MAX, COEF_MAX);
    push_pair(SAMPLE_MAX, SAMPLE_MAX);
    push_pair(SAMPLE_MIN, SAMPLE_MIN);
    push_pair(-1, -1);
    push_pair(1, 1);
    push_pair(12345, -12345);
    drain();

    // Unused selector code acts as no delay; most negative gain and cross coefficients, Q scale -1.0
    set_mode(2'd3, 1'b1, COEF_MIN, COEF_MIN, -COEF_ONE);
    push_pair(SAMPLE_MIN, SAMPLE_MIN);
    push_pair(SAMPLE_MAX, SAMPLE_MAX);
    push_pair(-3, 7);
    push_pair('0, SAMPLE_MIN);
    drain();

    // Unity correction of the sample extremes and a negative value
    set_mode(DELAY_NONE, 1'b1, COEF_ONE, '0, COEF_ONE);
    push_pair(SAMPLE_MIN, SAMPLE_MAX);
    push_pair(-1048577, 3);
    drain();

    // Random phases, each with its own register setting; groups of phases share an idle pattern
    for (ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 71;
      end else if (ph < 6) begin
        send_idle_pct = 71;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_mode(2'($urandom_range(3)), $urandom_range(3) != 0,
               pick_coef(), pick_coef(), pick_coef());
      for (k = 0; k < 100; k++) push_pair(pick_sample(), pick_sample());
      drain();
    end

    // Let the pipeline settle so any stray beat gets caught
    repeat (12) @(negedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
